// File: design/bm3_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bm3_pkg: shared types and constants for the 3x3 binary morphology block
// Frame size limits, derived widths, register indexes, the operation codes
// and the word that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package bm3_pkg;

    // Frame size limits.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Derived widths.
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int DIM_W  = COL_W + 1;
    localparam int ROW_W  = $clog2(MAX_HEIGHT) + 2;
    localparam int POS_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int ELEM_W     = 9;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MISS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;

    // Operation codes of the mode register.
    typedef enum logic [2:0] {
        MODE_ERODE   = 3'd0,
        MODE_DILATE  = 3'd1,
        MODE_OPEN    = 3'd2,
        MODE_CLOSE   = 3'd3,
        MODE_INNER   = 3'd4,
        MODE_OUTER   = 3'd5,
        MODE_GRAD    = 3'd6,
        MODE_HITMISS = 3'd7
    } mode_t;

    // Operation settings seen by the back part.
    typedef struct packed {
        mode_t             mode;
        logic [ELEM_W-1:0] hit;
        logic [ELEM_W-1:0] miss;
    } op_cfg_t;

    // One classified pixel word.
    typedef struct packed {
        logic              px;
        logic [COL_W-1:0]  col;
        logic [COL_W-1:0]  col_mid;
        logic              s1_valid;
        logic [8:0]        mask1;
        logic              emit;
        logic              last;
        logic [8:0]        mask2;
    } pix_word_t;

endpackage
`default_nettype wire

// File: design/bm3_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bm3_ram: generic single-write, single-read memory
// One write port and one read port with registered read data. A read of the
// address written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module bm3_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Storage and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: design/bm3_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bm3_div: restoring divider, one quotient bit per cycle
// Divides a frame position by the image width. A start pulse loads the
// operands; done pulses once the quotient and remainder are valid.
// ----------------------------------------------------------------------------
module bm3_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [bm3_pkg::POS_W-1:0] dividend,
    input  wire logic [bm3_pkg::DIM_W-1:0] divisor,
    output logic                           done,
    output logic      [bm3_pkg::POS_W-1:0] quotient,
    output logic      [bm3_pkg::DIM_W-1:0] remainder
);
    import bm3_pkg::*;

    localparam int CNT_W = $clog2(POS_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIM_W-1:0]  rem_reg, rem_next;
    logic [DIM_W-1:0]  dvs_reg, dvs_next;
    logic [POS_W-1:0]  quo_reg, quo_next;
    logic [DIM_W:0]    partial;
    logic [DIM_W:0]    trial;
    logic              fits;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign partial = {rem_reg, quo_reg[POS_W-1]};
    assign fits    = partial >= {1'b0, dvs_reg};
    assign trial   = partial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(POS_W);
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[DIM_W-1:0] : partial[DIM_W-1:0];
            quo_next = {quo_reg[POS_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state and operand registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

// File: design/bm3_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bm3_front: input acceptance and raster classification
// Tracks the frame position and the columns and rows of both window centres,
// and turns each accepted pixel into a word with line buffer addresses,
// edge masks and result flags. After reset or a register write it realigns
// its counters to the new frame size through the divider.
// ----------------------------------------------------------------------------
module bm3_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      pixel_in,
    input  wire logic [bm3_pkg::DIM_W-1:0] image_width,
    input  wire logic [bm3_pkg::DIM_W-1:0] image_height,
    input  wire logic                      cfg_written,
    output logic                           q_push,
    output bm3_pkg::pix_word_t             q_word,
    input  wire logic                      q_full
);
    import bm3_pkg::*;

    typedef enum logic [2:0] {
        ST_HOLD,
        ST_CHECK,
        ST_GO,
        ST_WAIT,
        ST_RUN
    } state_t;

    state_t            state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [COL_W-1:0]  x_reg, x_next;
    logic [COL_W-1:0]  xm_reg, xm_next;
    logic [COL_W-1:0]  x2_reg, x2_next;
    logic [ROW_W-1:0]  row1_reg, row1_next;
    logic [ROW_W-1:0]  row2_reg, row2_next;
    logic              on1_reg, on1_next;
    logic              on2_reg, on2_next;
    logic [POS_W-1:0]  npix_reg;
    logic [POS_W-1:0]  total_reg;

    logic [DIM_W-1:0]   w_eff, h_eff, wm1, wm2;
    logic [2*DIM_W-1:0] area;
    logic [COL_W-1:0]   wm1_col, x2_start;
    logic [POS_W-1:0]   w_plus1, w2_plus2, pos_inc;
    logic               accept, wrap;
    logic               div_start, div_done;
    logic [POS_W-1:0]   div_dividend, div_quo;
    logic [DIM_W-1:0]   div_rem;
    logic [COL_W-1:0]   rem_col, xm_cap, x2_cap;

    // Edge mask of a window centred at (row, col).
    function automatic logic [8:0] inside_mask(
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col,
        input logic [DIM_W-1:0] w,
        input logic [DIM_W-1:0] h
    );
        logic [8:0] m;
        m = '1;
        if (row == '0)
        begin
            m = m & 9'h1F8;
        end
        if (({1'b0, row} + (ROW_W+1)'(1)) >= (ROW_W+1)'(h))
        begin
            m = m & 9'h03F;
        end
        if (col == '0)
        begin
            m = m & 9'h1B6;
        end
        if (({1'b0, col} + DIM_W'(1)) >= w)
        begin
            m = m & 9'h0DB;
        end
        return m;
    endfunction

    // Column step with wrap at the end of the row.
    function automatic logic [COL_W-1:0] col_step(
        input logic [COL_W-1:0] c,
        input logic [DIM_W-1:0] last
    );
        return ({1'b0, c} == last) ? '0 : c + COL_W'(1);
    endfunction

    // Frame size with out-of-range values clamped.
    always_comb
    begin
        if (image_width == '0)
            w_eff = DIM_W'(1);
        else if (image_width > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = image_width;
        if (image_height == '0)
            h_eff = DIM_W'(1);
        else if (image_height > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = image_height;
    end

    assign area     = w_eff * h_eff;
    assign wm1      = w_eff - DIM_W'(1);
    assign wm2      = w_eff - DIM_W'(2);
    assign wm1_col  = wm1[COL_W-1:0];
    assign x2_start = (w_eff == DIM_W'(1)) ? '0 : wm2[COL_W-1:0];
    assign w_plus1  = POS_W'(w_eff) + POS_W'(1);
    assign w2_plus2 = (POS_W'(w_eff) << 1) + POS_W'(2);
    assign pos_inc  = pos_reg + POS_W'(1);
    assign wrap     = pos_inc >= total_reg;

    // Handshake and classified word.
    assign in_stall = (state_reg != ST_RUN) || q_full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = accept;

    always_comb
    begin
        q_word.px       = (pos_reg < npix_reg) && pixel_in;
        q_word.col      = x_reg;
        q_word.col_mid  = xm_reg;
        q_word.s1_valid = on1_reg && (row1_reg < ROW_W'(h_eff));
        q_word.mask1    = inside_mask(row1_reg, xm_reg, w_eff, h_eff);
        q_word.emit     = on2_reg;
        q_word.last     = on2_reg && (row2_reg == ROW_W'(h_eff) - ROW_W'(1))
                          && ({1'b0, x2_reg} == wm1);
        q_word.mask2    = inside_mask(row2_reg, x2_reg, w_eff, h_eff);
    end

    // Realignment: divide the position and both centre positions by width.
    always_comb
    begin
        unique case (phase_reg)
            2'd0:    div_dividend = pos_reg;
            2'd1:    div_dividend = pos_reg - w_plus1;
            default: div_dividend = pos_reg - w2_plus2;
        endcase
    end

    assign rem_col = div_rem[COL_W-1:0];
    assign xm_cap  = (rem_col == '0) ? wm1_col : rem_col - COL_W'(1);
    assign x2_cap  = (xm_cap == '0) ? wm1_col : xm_cap - COL_W'(1);

    bm3_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (w_eff),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Sequencer and position counters.
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        pos_next   = pos_reg;
        x_next     = x_reg;
        xm_next    = xm_reg;
        x2_next    = x2_reg;
        row1_next  = row1_reg;
        row2_next  = row2_reg;
        on1_next   = on1_reg;
        on2_next   = on2_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_HOLD:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (pos_reg >= total_reg)
                begin
                    pos_next = '0;
                end
                phase_next = 2'd0;
                state_next = ST_GO;
            end
            ST_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    unique case (phase_reg)
                        2'd0:
                        begin
                            x_next     = rem_col;
                            xm_next    = xm_cap;
                            x2_next    = x2_cap;
                            on1_next   = pos_reg >= w_plus1;
                            on2_next   = pos_reg >= w2_plus2;
                            phase_next = 2'd1;
                            state_next = ST_GO;
                        end
                        2'd1:
                        begin
                            row1_next  = div_quo[ROW_W-1:0];
                            phase_next = 2'd2;
                            state_next = ST_GO;
                        end
                        default:
                        begin
                            row2_next  = div_quo[ROW_W-1:0];
                            state_next = ST_RUN;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                if (accept)
                begin
                    if (wrap)
                    begin
                        pos_next = '0;
                        x_next   = '0;
                        xm_next  = wm1_col;
                        x2_next  = x2_start;
                        on1_next = 1'b0;
                        on2_next = 1'b0;
                    end
                    else
                    begin
                        pos_next = pos_inc;
                        x_next   = col_step(x_reg, wm1);
                        xm_next  = col_step(xm_reg, wm1);
                        x2_next  = col_step(x2_reg, wm1);
                        if (pos_inc == w_plus1)
                        begin
                            on1_next  = 1'b1;
                            row1_next = '0;
                        end
                        else if (on1_reg && ({1'b0, xm_reg} == wm1))
                        begin
                            row1_next = row1_reg + ROW_W'(1);
                        end
                        if (pos_inc == w2_plus2)
                        begin
                            on2_next  = 1'b1;
                            row2_next = '0;
                        end
                        else if (on2_reg && ({1'b0, x2_reg} == wm1))
                        begin
                            row2_next = row2_reg + ROW_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_HOLD;
            end
        endcase
        if (cfg_written)
        begin
            state_next = ST_HOLD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HOLD;
            phase_reg <= 2'd0;
            pos_reg   <= '0;
            x_reg     <= '0;
            xm_reg    <= '0;
            x2_reg    <= '0;
            row1_reg  <= '0;
            row2_reg  <= '0;
            on1_reg   <= 1'b0;
            on2_reg   <= 1'b0;
            npix_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            x_reg     <= x_next;
            xm_reg    <= xm_next;
            x2_reg    <= x2_next;
            row1_reg  <= row1_next;
            row2_reg  <= row2_next;
            on1_reg   <= on1_next;
            on2_reg   <= on2_next;
            npix_reg  <= area[POS_W-1:0];
            total_reg <= area[POS_W-1:0] + w2_plus2;
        end
    end

endmodule
`default_nettype wire

// File: design/bm3_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bm3_queue: short word queue between the front and back parts
// Four entries; lets the input side and the processing side stall on their
// own.
// ----------------------------------------------------------------------------
module bm3_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire bm3_pkg::pix_word_t word_in,
    output logic                    full,
    input  wire logic               pop,
    output bm3_pkg::pix_word_t      word_out,
    output logic                    empty
);
    import bm3_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    pix_word_t         mem_reg [DEPTH];
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [PTR_W:0]    cnt_reg, cnt_next;

    assign full     = cnt_reg == (PTR_W+1)'(DEPTH);
    assign empty    = cnt_reg == '0;
    assign word_out = mem_reg[rptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wptr_next = push ? wptr_reg + PTR_W'(1) : wptr_reg;
        rptr_next = pop ? rptr_reg + PTR_W'(1) : rptr_reg;
        cnt_next  = cnt_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= word_in;
        end
    end

endmodule
`default_nettype wire

// File: design/bm3_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bm3_back: line buffers, windows and the morphology operation
// Stage one reads both line buffer pairs; stage two shifts the columns into
// the two 3x3 windows, applies the operation and writes the line buffers.
// Results go into a small output queue that the back part never overfills.
// ----------------------------------------------------------------------------
module bm3_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_empty,
    output logic                    q_pop,
    input  wire bm3_pkg::pix_word_t q_word,
    input  wire bm3_pkg::op_cfg_t   op_cfg,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    pixel_out,
    output logic                    frame_last
);
    import bm3_pkg::*;

    localparam int OUT_DEPTH = 4;
    localparam int OPTR_W    = $clog2(OUT_DEPTH);

    pix_word_t         b2_word_reg;
    logic              b2_valid_reg;
    logic [8:0]        swin_reg, swin_next;
    logic [8:0]        mwin_reg, mwin_next;
    logic              byp_valid_reg;
    logic [COL_W-1:0]  byp_src_addr_reg, byp_mid_addr_reg;
    logic [1:0]        byp_src_data_reg, byp_mid_data_reg;
    logic [1:0]        out_mem_reg [OUT_DEPTH];
    logic [OPTR_W-1:0] owptr_reg, orptr_reg;
    logic [OPTR_W:0]   ocnt_reg;

    logic [1:0]        src_rdata, mid_rdata, src_rd, mid_rd;
    logic [1:0]        src_wdata, mid_wdata;
    logic              s1, res, out_push, out_pop;
    logic [8:0]        pres1, pres2, comp2;

    // Shift a new column into a 3x3 window.
    function automatic logic [8:0] push_win(
        input logic [8:0] win,
        input logic       top,
        input logic       mid,
        input logic       px
    );
        return ((win >> 1) & 9'h0DB) | {px, 2'b00, mid, 2'b00, top, 2'b00};
    endfunction

    function automatic logic erode(input logic [8:0] pres, input logic [8:0] elem);
        return pres[4] && ((elem & ~pres) == 9'h000);
    endfunction

    function automatic logic dilate(input logic [8:0] pres, input logic [8:0] elem);
        return pres[4] || ((elem & pres) != 9'h000);
    endfunction

    // Stage one: pop a word when the output queue has room for it.
    assign q_pop = !q_empty
                   && (({1'b0, ocnt_reg} + (OPTR_W+2)'(b2_valid_reg))
                       < (OPTR_W+2)'(OUT_DEPTH));

    bm3_ram #(.WIDTH(2), .DEPTH(MAX_WIDTH)) u_src_rows (
        .clk   (clk),
        .we    (b2_valid_reg),
        .waddr (b2_word_reg.col),
        .wdata (src_wdata),
        .re    (q_pop),
        .raddr (q_word.col),
        .rdata (src_rdata)
    );

    bm3_ram #(.WIDTH(2), .DEPTH(MAX_WIDTH)) u_mid_rows (
        .clk   (clk),
        .we    (b2_valid_reg),
        .waddr (b2_word_reg.col_mid),
        .wdata (mid_wdata),
        .re    (q_pop),
        .raddr (q_word.col_mid),
        .rdata (mid_rdata)
    );

    // Stage two: forward the previous write when it hit the same column.
    assign src_rd = (byp_valid_reg && (byp_src_addr_reg == b2_word_reg.col))
                    ? byp_src_data_reg : src_rdata;
    assign mid_rd = (byp_valid_reg && (byp_mid_addr_reg == b2_word_reg.col_mid))
                    ? byp_mid_data_reg : mid_rdata;

    // First window: source pixels, with opening or closing pre-pass.
    always_comb
    begin
        swin_next = push_win(swin_reg, src_rd[1], src_rd[0], b2_word_reg.px);
        pres1     = swin_next & b2_word_reg.mask1;
        s1        = 1'b0;
        if (b2_word_reg.s1_valid)
        begin
            if (op_cfg.mode == MODE_OPEN)
                s1 = erode(pres1, op_cfg.hit);
            else if (op_cfg.mode == MODE_CLOSE)
                s1 = dilate(pres1, op_cfg.hit);
            else
                s1 = swin_next[4];
        end
        src_wdata = {src_rd[0], b2_word_reg.px};
    end

    // Second window: the operation of the selected mode.
    always_comb
    begin
        mwin_next = push_win(mwin_reg, mid_rd[1], mid_rd[0], s1);
        pres2     = mwin_next & b2_word_reg.mask2;
        comp2     = ~mwin_next & b2_word_reg.mask2;
        unique case (op_cfg.mode)
            MODE_ERODE:   res = erode(pres2, op_cfg.hit);
            MODE_DILATE:  res = dilate(pres2, op_cfg.hit);
            MODE_OPEN:    res = dilate(pres2, op_cfg.hit);
            MODE_CLOSE:   res = erode(pres2, op_cfg.hit);
            MODE_INNER:   res = mwin_next[4] && !erode(pres2, op_cfg.hit);
            MODE_OUTER:   res = dilate(pres2, op_cfg.hit) && !mwin_next[4];
            MODE_GRAD:    res = dilate(pres2, op_cfg.hit) && !erode(pres2, op_cfg.hit);
            MODE_HITMISS: res = erode(pres2, op_cfg.hit) && erode(comp2, op_cfg.miss);
        endcase
        mid_wdata = {mid_rd[0], s1};
    end

    // Output queue handshake.
    assign out_push   = b2_valid_reg && b2_word_reg.emit;
    assign out_valid  = ocnt_reg != '0;
    assign out_pop    = out_valid && !out_stall;
    assign pixel_out  = out_mem_reg[orptr_reg][1];
    assign frame_last = out_mem_reg[orptr_reg][0];

    // Control state: stage valid, windows, forwarding flag, queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b2_valid_reg  <= 1'b0;
            swin_reg      <= '0;
            mwin_reg      <= '0;
            byp_valid_reg <= 1'b0;
            owptr_reg     <= '0;
            orptr_reg     <= '0;
            ocnt_reg      <= '0;
        end
        else
        begin
            b2_valid_reg  <= q_pop;
            byp_valid_reg <= b2_valid_reg;
            if (b2_valid_reg)
            begin
                swin_reg <= swin_next;
                mwin_reg <= mwin_next;
            end
            if (out_push)
            begin
                owptr_reg <= owptr_reg + OPTR_W'(1);
            end
            if (out_pop)
            begin
                orptr_reg <= orptr_reg + OPTR_W'(1);
            end
            ocnt_reg <= ocnt_reg + (OPTR_W+1)'(out_push) - (OPTR_W+1)'(out_pop);
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b2_word_reg <= q_word;
        end
        byp_src_addr_reg <= b2_word_reg.col;
        byp_mid_addr_reg <= b2_word_reg.col_mid;
        byp_src_data_reg <= src_wdata;
        byp_mid_data_reg <= mid_wdata;
        if (out_push)
        begin
            out_mem_reg[owptr_reg] <= {res, b2_word_reg.last};
        end
    end

endmodule
`default_nettype wire

// File: design/binary_morphology_3x3.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_morphology_3x3: 3x3 binary morphology on a raster pixel stream
// Input words carry one pixel each in raster order; each frame is followed
// by 2*width+2 padding words that flush the two line-buffered windows. An
// output word appears for every input word whose delayed raster position
// lies in the frame, with frame_last set on the last pixel of the frame.
// Throughput is one word per clock in steady state; the result word for an
// input word passes through the queue, the registered line buffer read and
// the output queue.
// Configuration writes (cfg_valid/cfg_ready, index and data) are taken at
// any time and realign the frame counters through a 21-step divider per
// pass, three passes, during which in_stall is high. The same realignment
// runs after reset. When the receiver raises out_stall, results collect in a
// four-word output queue and then in the input queue, and in_stall rises
// once both are full; nothing is lost.
// Reset clears registers to mode erode, full hit element, empty miss
// element and a 1024 x 1024 frame.
// ----------------------------------------------------------------------------
module binary_morphology_3x3 (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           pixel_in,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                pixel_out,
    output logic                                frame_last,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bm3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bm3_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bm3_pkg::*;

    mode_t             mode_reg;
    logic [ELEM_W-1:0] hit_reg;
    logic [ELEM_W-1:0] miss_reg;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic              cfg_wr;
    op_cfg_t           op_cfg;
    logic              q_push, q_full, q_pop, q_empty;
    pix_word_t         q_word_in, q_word_out;

    // Register file.
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_ERODE;
            hit_reg    <= '1;
            miss_reg   <= '0;
            width_reg  <= DIM_W'(MAX_WIDTH);
            height_reg <= DIM_W'(MAX_HEIGHT);
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                REG_MODE:   mode_reg   <= mode_t'(cfg_data[2:0]);
                REG_HIT:    hit_reg    <= cfg_data[ELEM_W-1:0];
                REG_MISS:   miss_reg   <= cfg_data[ELEM_W-1:0];
                REG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    assign op_cfg.mode = mode_reg;
    assign op_cfg.hit  = hit_reg;
    assign op_cfg.miss = miss_reg;

    // Front part: acceptance and classification.
    bm3_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_in     (pixel_in),
        .image_width  (width_reg),
        .image_height (height_reg),
        .cfg_written  (cfg_wr),
        .q_push       (q_push),
        .q_word       (q_word_in),
        .q_full       (q_full)
    );

    // Queue between the two parts.
    bm3_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .word_in  (q_word_in),
        .full     (q_full),
        .pop      (q_pop),
        .word_out (q_word_out),
        .empty    (q_empty)
    );

    // Back part: line buffers, windows and results.
    bm3_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .q_word     (q_word_out),
        .op_cfg     (op_cfg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_out  (pixel_out),
        .frame_last (frame_last)
    );

endmodule
`default_nettype wire
